// File: src/srs_pkg.sv
package srs_pkg;

    // defaults for the top-level parameters
    localparam int WINDOW_DEF    = 8;
    localparam int SEQ_SPACE_DEF = 16;

    // field widths on the ports
    localparam int KIND_W    = 2;
    localparam int PSUM_W    = 13;
    localparam int SEQNUM_W  = 4;
    localparam int CKS_W     = 13;
    localparam int ACTION_W  = 3;
    localparam int SLOTNUM_W = 3;
    localparam int TIMER_W   = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_MSG     = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_RSVD    = 2'd3
    } kind_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_SEND     = 3'd1,
        ACT_RESEND   = 3'd2,
        ACT_FULL     = 3'd3,
        ACT_NEW_ACK  = 3'd4,
        ACT_DUP      = 3'd5,
        ACT_CORRUPT  = 3'd6,
        ACT_IDLE_TO  = 3'd7
    } action_t;

    typedef enum logic [TIMER_W-1:0] {
        TMR_LEAVE   = 2'd0,
        TMR_START   = 2'd1,
        TMR_RESTART = 2'd2,
        TMR_STOP    = 2'd3
    } timer_t;

    // which slot address drives the slot memory read port
    typedef enum logic [1:0] {
        RD_FIRST = 2'd0,
        RD_LAST  = 2'd1,
        RD_ACK   = 2'd2,
        RD_SCAN  = 2'd3
    } rd_sel_t;

    // where the frame fields of a result come from
    typedef enum logic [1:0] {
        RES_PLAIN  = 2'd0,
        RES_SEND   = 2'd1,
        RES_RESEND = 2'd2
    } res_src_t;

    typedef struct packed {
        logic     cap_in;
        rd_sel_t  rd_sel;
        logic     do_send;
        logic     ack_mark;
        logic     cap_sf;
        logic     cap_sl;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     slide_step;
        logic     scan_init;
        logic     scan_step;
        logic     res_load;
        action_t  res_act;
        timer_t   res_tmr;
        res_src_t res_src;
        logic     out_load;
    } srs_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  corrupt;
        logic  none_out;
        logic  ack_ok;
        logic  ack_is_first;
        logic  slide_stop;
        logic  scan_acked;
        logic  iter_done;
    } srs_stat_t;

endpackage

// File: src/srs_dp.sv
module srs_dp #(
    parameter int WINDOW    = srs_pkg::WINDOW_DEF,
    parameter int SEQ_SPACE = srs_pkg::SEQ_SPACE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  srs_pkg::srs_cmd_t              cmd,
    output srs_pkg::srs_stat_t             stat,
    input  logic [srs_pkg::KIND_W-1:0]     in_kind,
    input  logic [srs_pkg::PSUM_W-1:0]     in_payload_sum,
    input  logic [srs_pkg::SEQNUM_W-1:0]   in_ack_seqnum,
    input  logic [srs_pkg::SEQNUM_W-1:0]   in_ack_number,
    input  logic [srs_pkg::CKS_W-1:0]      in_ack_checksum,
    output logic [srs_pkg::ACTION_W-1:0]   out_action,
    output logic [srs_pkg::SEQNUM_W-1:0]   out_frame_seqnum,
    output logic [srs_pkg::CKS_W-1:0]      out_frame_checksum,
    output logic [srs_pkg::SLOTNUM_W-1:0]  out_frame_slot,
    output logic [srs_pkg::TIMER_W-1:0]    out_timer_cmd
);
    import srs_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SEQ_W   = $clog2(SEQ_SPACE);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SEQ_N   = 1 << SEQ_W;
    localparam int ACKN_N  = 1 << SEQNUM_W;
    localparam int TBL_N   = (SEQ_N > ACKN_N) ? SEQ_N : ACKN_N;
    localparam int SEQX_W  = (SEQ_W > SEQNUM_W) ? SEQ_W : SEQNUM_W;
    localparam int SLOTX_W = (SLOT_W > SLOTNUM_W) ? SLOT_W : SLOTNUM_W;

    // value mod WINDOW for every narrow value
    function automatic logic [TBL_N*SLOT_W-1:0] build_slot_of();
        logic [TBL_N*SLOT_W-1:0] t;
        int                      s;
        t = '0;
        s = 0;
        for (int i = 0; i < TBL_N; i++) begin
            t[i*SLOT_W +: SLOT_W] = SLOT_W'(s);
            s = (s == WINDOW - 1) ? 0 : s + 1;
        end
        return t;
    endfunction

    localparam logic [TBL_N*SLOT_W-1:0] SLOT_OF = build_slot_of();

    // slot of the sequence number that follows a stored one
    function automatic logic [SEQ_N*SLOT_W-1:0] build_next_slot();
        logic [SEQ_N*SLOT_W-1:0] t;
        int                      j;
        t = '0;
        for (int i = 0; i < SEQ_SPACE; i++) begin
            j = (i + 1 == SEQ_SPACE) ? 0 : i + 1;
            t[i*SLOT_W +: SLOT_W] = SLOT_OF[j*SLOT_W +: SLOT_W];
        end
        return t;
    endfunction

    localparam logic [SEQ_N*SLOT_W-1:0] NEXT_SLOT = build_next_slot();

    // window state
    logic [SEQ_W-1:0]  next_seq_reg;
    logic [SLOT_W-1:0] first_slot_reg;
    logic [SLOT_W-1:0] last_slot_reg;
    logic [CNT_W-1:0]  outstanding_reg;
    logic [CNT_W-1:0]  acked_cnt_reg;
    logic [WINDOW-1:0] acked_reg;

    // slot memory, one read port
    logic [SEQ_W-1:0]  seq_mem [WINDOW];
    logic [CKS_W-1:0]  cks_mem [WINDOW];
    logic [SEQ_W-1:0]  rd_seq_reg;
    logic [CKS_W-1:0]  rd_cks_reg;
    logic [SLOT_W-1:0] rd_addr;

    // captured item
    kind_t                kind_reg;
    logic [PSUM_W-1:0]    psum_reg;
    logic [SEQNUM_W-1:0]  aseq_reg;
    logic [SEQNUM_W-1:0]  anum_reg;
    logic [CKS_W-1:0]     acks_reg;

    logic [SEQ_W-1:0]  sf_reg;
    logic [SEQ_W-1:0]  sl_reg;
    logic [CNT_W-1:0]  iter_reg;
    logic [SLOT_W-1:0] scan_reg;

    // pending result and output register
    action_t               res_act_reg;
    timer_t                res_tmr_reg;
    logic [SEQNUM_W-1:0]   res_seq_reg;
    logic [CKS_W-1:0]      res_cks_reg;
    logic [SLOTNUM_W-1:0]  res_slot_reg;
    action_t               m_act_reg;
    timer_t                m_tmr_reg;
    logic [SEQNUM_W-1:0]   m_seq_reg;
    logic [CKS_W-1:0]      m_cks_reg;
    logic [SLOTNUM_W-1:0]  m_slot_reg;

    logic [SLOT_W-1:0]  send_slot;
    logic [SLOT_W-1:0]  ack_slot;
    logic [SLOT_W-1:0]  adv_slot;
    logic [CKS_W-1:0]   send_cks;
    logic [CKS_W:0]     ack_want;
    logic [CNT_W:0]     fill;
    logic [SEQX_W-1:0]  sf_x;
    logic [SEQX_W-1:0]  sl_x;
    logic [SEQX_W-1:0]  an_x;
    logic [SEQX_W-1:0]  rd_x;
    logic [SEQX_W-1:0]  send_seq_x;
    logic [SLOTX_W-1:0] send_slot_x;
    logic [SLOTX_W-1:0] scan_slot_x;
    logic               in_window;

    assign send_slot = SLOT_OF[next_seq_reg * SLOT_W +: SLOT_W];
    assign ack_slot  = SLOT_OF[anum_reg * SLOT_W +: SLOT_W];
    assign adv_slot  = NEXT_SLOT[rd_seq_reg * SLOT_W +: SLOT_W];

    // seq minus one plus payload sum, wrapped to the checksum width
    assign send_cks = psum_reg + CKS_W'(next_seq_reg) - CKS_W'(1);

    // exact comparison, one bit wider than the fields
    assign ack_want = {psum_reg[PSUM_W-1], psum_reg} + (CKS_W+1)'(aseq_reg)
                    + (CKS_W+1)'(anum_reg);

    assign fill = {1'b0, outstanding_reg} + {1'b0, acked_cnt_reg};

    assign sf_x        = SEQX_W'(sf_reg);
    assign sl_x        = SEQX_W'(sl_reg);
    assign an_x        = SEQX_W'(anum_reg);
    assign rd_x        = SEQX_W'(rd_seq_reg);
    assign send_seq_x  = SEQX_W'(next_seq_reg);
    assign send_slot_x = SLOTX_W'(send_slot);
    assign scan_slot_x = SLOTX_W'(scan_reg);

    // window test with wrap of the sequence space
    assign in_window = (sf_x <= sl_x) ? (an_x >= sf_x && an_x <= sl_x)
                                      : (an_x >= sf_x || an_x <= sl_x);

    always_comb begin
        stat.kind         = kind_reg;
        stat.full         = fill >= (CNT_W+1)'(WINDOW);
        stat.corrupt      = ack_want != {acks_reg[CKS_W-1], acks_reg};
        stat.none_out     = outstanding_reg == '0;
        stat.ack_ok       = in_window && !acked_reg[ack_slot] && (rd_x == an_x);
        stat.ack_is_first = ack_slot == first_slot_reg;
        stat.slide_stop   = (acked_cnt_reg == '0) || !acked_reg[first_slot_reg];
        stat.scan_acked   = acked_reg[scan_reg];
        stat.iter_done    = iter_reg == CNT_W'(WINDOW);
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_FIRST: rd_addr = first_slot_reg;
            RD_LAST:  rd_addr = last_slot_reg;
            RD_ACK:   rd_addr = ack_slot;
            RD_SCAN:  rd_addr = scan_reg;
            default:  rd_addr = first_slot_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_send) begin
            seq_mem[send_slot] <= next_seq_reg;
            cks_mem[send_slot] <= send_cks;
        end
        rd_seq_reg <= seq_mem[rd_addr];
        rd_cks_reg <= cks_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_seq_reg    <= '0;
            first_slot_reg  <= '0;
            last_slot_reg   <= SLOT_W'(WINDOW - 1);
            outstanding_reg <= '0;
            acked_cnt_reg   <= '0;
            acked_reg       <= '0;
        end else begin
            if (cmd.do_send) begin
                acked_reg[send_slot] <= 1'b0;
                last_slot_reg        <= send_slot;
                outstanding_reg      <= outstanding_reg + CNT_W'(1);
                next_seq_reg         <= (next_seq_reg == SEQ_W'(SEQ_SPACE - 1))
                                        ? '0 : next_seq_reg + SEQ_W'(1);
            end
            if (cmd.ack_mark) begin
                acked_reg[ack_slot] <= 1'b1;
                outstanding_reg     <= outstanding_reg - CNT_W'(1);
                acked_cnt_reg       <= acked_cnt_reg + CNT_W'(1);
            end
            if (cmd.slide_step) begin
                acked_reg[first_slot_reg] <= 1'b0;
                acked_cnt_reg             <= acked_cnt_reg - CNT_W'(1);
                first_slot_reg            <= adv_slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            kind_reg <= kind_t'(in_kind);
            psum_reg <= in_payload_sum;
            aseq_reg <= in_ack_seqnum;
            anum_reg <= in_ack_number;
            acks_reg <= in_ack_checksum;
        end
        if (cmd.cap_sf) begin
            sf_reg <= rd_seq_reg;
        end
        if (cmd.cap_sl) begin
            sl_reg <= rd_seq_reg;
        end
        if (cmd.cnt_clr) begin
            iter_reg <= '0;
        end else if (cmd.cnt_inc) begin
            iter_reg <= iter_reg + CNT_W'(1);
        end
        if (cmd.scan_init) begin
            scan_reg <= first_slot_reg;
        end else if (cmd.scan_step) begin
            scan_reg <= adv_slot;
        end
        if (cmd.res_load) begin
            res_act_reg <= cmd.res_act;
            res_tmr_reg <= cmd.res_tmr;
            case (cmd.res_src)
                RES_SEND: begin
                    res_seq_reg  <= send_seq_x[SEQNUM_W-1:0];
                    res_cks_reg  <= send_cks;
                    res_slot_reg <= send_slot_x[SLOTNUM_W-1:0];
                end
                RES_RESEND: begin
                    res_seq_reg  <= rd_x[SEQNUM_W-1:0];
                    res_cks_reg  <= rd_cks_reg;
                    res_slot_reg <= scan_slot_x[SLOTNUM_W-1:0];
                end
                default: begin
                    res_seq_reg  <= '0;
                    res_cks_reg  <= '0;
                    res_slot_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_act_reg  <= res_act_reg;
            m_tmr_reg  <= res_tmr_reg;
            m_seq_reg  <= res_seq_reg;
            m_cks_reg  <= res_cks_reg;
            m_slot_reg <= res_slot_reg;
        end
    end

    assign out_action         = m_act_reg;
    assign out_frame_seqnum   = m_seq_reg;
    assign out_frame_checksum = m_cks_reg;
    assign out_frame_slot     = m_slot_reg;
    assign out_timer_cmd      = m_tmr_reg;

endmodule

// File: src/srs_ctrl.sv
module srs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  srs_pkg::srs_stat_t stat,
    output srs_pkg::srs_cmd_t  cmd
);
    import srs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ACK1,
        S_ACK2,
        S_ACK3,
        S_SLIDE,
        S_SLIDE_ADV,
        S_SCAN,
        S_SCAN_ADV,
        S_RESEND,
        S_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.res_src = RES_PLAIN;
                unique case (stat.kind)
                    KIND_MSG: begin
                        cmd.res_load = 1'b1;
                        state_next   = S_PUT;
                        if (stat.full) begin
                            cmd.res_act = ACT_FULL;
                            cmd.res_tmr = TMR_LEAVE;
                        end else begin
                            cmd.do_send = 1'b1;
                            cmd.res_act = ACT_SEND;
                            cmd.res_src = RES_SEND;
                            cmd.res_tmr = stat.none_out ? TMR_START : TMR_LEAVE;
                        end
                    end
                    KIND_ACK: begin
                        cmd.res_tmr = TMR_LEAVE;
                        if (stat.corrupt) begin
                            cmd.res_load = 1'b1;
                            cmd.res_act  = ACT_CORRUPT;
                            state_next   = S_PUT;
                        end else if (stat.none_out) begin
                            cmd.res_load = 1'b1;
                            cmd.res_act  = ACT_DUP;
                            state_next   = S_PUT;
                        end else begin
                            cmd.rd_sel = RD_FIRST;
                            state_next = S_ACK1;
                        end
                    end
                    KIND_TIMEOUT: begin
                        if (stat.none_out) begin
                            cmd.res_load = 1'b1;
                            cmd.res_act  = ACT_IDLE_TO;
                            cmd.res_tmr  = TMR_LEAVE;
                            state_next   = S_PUT;
                        end else begin
                            cmd.scan_init = 1'b1;
                            cmd.cnt_clr   = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_act  = ACT_NONE;
                        cmd.res_tmr  = TMR_LEAVE;
                        state_next   = S_PUT;
                    end
                endcase
            end
            S_ACK1: begin
                cmd.cap_sf = 1'b1;
                cmd.rd_sel = RD_LAST;
                state_next = S_ACK2;
            end
            S_ACK2: begin
                cmd.cap_sl = 1'b1;
                cmd.rd_sel = RD_ACK;
                state_next = S_ACK3;
            end
            S_ACK3: begin
                cmd.res_src = RES_PLAIN;
                cmd.res_tmr = TMR_LEAVE;
                if (!stat.ack_ok) begin
                    cmd.res_load = 1'b1;
                    cmd.res_act  = ACT_DUP;
                    state_next   = S_PUT;
                end else begin
                    cmd.ack_mark = 1'b1;
                    if (stat.ack_is_first) begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_SLIDE;
                    end else begin
                        cmd.res_load = 1'b1;
                        cmd.res_act  = ACT_NEW_ACK;
                        state_next   = S_PUT;
                    end
                end
            end
            S_SLIDE: begin
                if (stat.iter_done || stat.slide_stop) begin
                    cmd.res_load = 1'b1;
                    cmd.res_act  = ACT_NEW_ACK;
                    cmd.res_src  = RES_PLAIN;
                    cmd.res_tmr  = stat.none_out ? TMR_STOP : TMR_RESTART;
                    state_next   = S_PUT;
                end else begin
                    cmd.rd_sel = RD_FIRST;
                    state_next = S_SLIDE_ADV;
                end
            end
            S_SLIDE_ADV: begin
                cmd.slide_step = 1'b1;
                cmd.cnt_inc    = 1'b1;
                state_next     = S_SLIDE;
            end
            S_SCAN: begin
                if (stat.iter_done) begin
                    cmd.res_load = 1'b1;
                    cmd.res_act  = ACT_IDLE_TO;
                    cmd.res_src  = RES_PLAIN;
                    cmd.res_tmr  = TMR_LEAVE;
                    state_next   = S_PUT;
                end else begin
                    cmd.rd_sel = RD_SCAN;
                    state_next = stat.scan_acked ? S_SCAN_ADV : S_RESEND;
                end
            end
            S_SCAN_ADV: begin
                cmd.scan_step = 1'b1;
                cmd.cnt_inc   = 1'b1;
                state_next    = S_SCAN;
            end
            S_RESEND: begin
                cmd.res_load = 1'b1;
                cmd.res_act  = ACT_RESEND;
                cmd.res_src  = RES_RESEND;
                cmd.res_tmr  = TMR_START;
                state_next   = S_PUT;
            end
            S_PUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: src/selective_repeat_sender.sv
// channel  dir  tdata (lowest bit up)                        tuser
// -------  ---  -------------------------------------------  -----------------
// s_       in   payload_sum 13, ack_seqnum 4, ack_number 4,  kind 2
//               ack_checksum 13, zero pad to 40
// m_       out  frame_seqnum 4, frame_checksum 13,           action 3
//               frame_slot 3, timer_cmd 2, zero pad to 24
//
// one event at a time, one result each
// new message: send, or full; ack: corrupt or duplicate, or marked, sliding over acked slots
//   when the oldest frame is acked; timeout: idle, or a scan for the oldest open frame to resend
// the single read port of the slot memory sets the pace of the slide and the resend scan
// synchronous active-low reset clears window state and all acked flags at once, no sweep
// a result waits in the output register while the next event runs; the next result then
// holds the sequencer until the waiting transfer completes
module selective_repeat_sender #(
    parameter int WINDOW    = srs_pkg::WINDOW_DEF,
    parameter int SEQ_SPACE = srs_pkg::SEQ_SPACE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input events
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [srs_pkg::S_TDATA_W-1:0]  s_tdata,   // payload_sum, ack_seqnum, ack_number, ack_checksum
    input  logic [srs_pkg::KIND_W-1:0]     s_tuser,   // kind
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srs_pkg::M_TDATA_W-1:0]  m_tdata,   // frame_seqnum, frame_checksum, frame_slot, timer_cmd
    output logic [srs_pkg::ACTION_W-1:0]   m_tuser    // action
);
    import srs_pkg::*;

    localparam int PAD_W = M_TDATA_W - SEQNUM_W - CKS_W - SLOTNUM_W - TIMER_W;

    srs_cmd_t  cmd;
    srs_stat_t stat;

    // unpacked input fields
    logic [PSUM_W-1:0]    in_payload_sum;
    logic [SEQNUM_W-1:0]  in_ack_seqnum;
    logic [SEQNUM_W-1:0]  in_ack_number;
    logic [CKS_W-1:0]     in_ack_checksum;

    // result fields from the output register
    logic [SEQNUM_W-1:0]  out_frame_seqnum;
    logic [CKS_W-1:0]     out_frame_checksum;
    logic [SLOTNUM_W-1:0] out_frame_slot;
    logic [TIMER_W-1:0]   out_timer_cmd;

    assign in_payload_sum  = s_tdata[PSUM_W-1:0];
    assign in_ack_seqnum   = s_tdata[PSUM_W +: SEQNUM_W];
    assign in_ack_number   = s_tdata[PSUM_W+SEQNUM_W +: SEQNUM_W];
    assign in_ack_checksum = s_tdata[PSUM_W+2*SEQNUM_W +: CKS_W];

    assign m_tdata = {{PAD_W{1'b0}}, out_timer_cmd, out_frame_slot,
                      out_frame_checksum, out_frame_seqnum};

    // sequencer: accepts events, walks the window, hands results to the output register
    srs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // window registers, slot memory, acked flags and result registers
    srs_dp #(
        .WINDOW    (WINDOW),
        .SEQ_SPACE (SEQ_SPACE)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .in_kind            (s_tuser),
        .in_payload_sum     (in_payload_sum),
        .in_ack_seqnum      (in_ack_seqnum),
        .in_ack_number      (in_ack_number),
        .in_ack_checksum    (in_ack_checksum),
        .out_action         (m_tuser),
        .out_frame_seqnum   (out_frame_seqnum),
        .out_frame_checksum (out_frame_checksum),
        .out_frame_slot     (out_frame_slot),
        .out_timer_cmd      (out_timer_cmd)
    );

endmodule

// File: verif/srs_window_checker.sv
`timescale 1ns / 1ps

// watches both channels of the sender window, predicts every result and compares
module srs_window_checker #(
    parameter int WINDOW    = srs_pkg::WINDOW_DEF,
    parameter int SEQ_SPACE = srs_pkg::SEQ_SPACE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [srs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [srs_pkg::KIND_W-1:0]    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [srs_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [srs_pkg::ACTION_W-1:0]  m_tuser,
    output int                            mismatches,
    output int                            pending,
    output int                            compared,
    output logic [7:0]                    actions_seen,
    output logic [3:0]                    timers_seen,
    output logic [srs_pkg::SEQNUM_W-1:0]  next_seq_view
);
    import srs_pkg::*;

    // bit offsets inside tdata
    localparam int PSUM_LO = 0;
    localparam int ASEQ_LO = PSUM_LO + PSUM_W;
    localparam int ANUM_LO = ASEQ_LO + SEQNUM_W;
    localparam int ACKS_LO = ANUM_LO + SEQNUM_W;
    localparam int FSEQ_LO = 0;
    localparam int FCKS_LO = FSEQ_LO + SEQNUM_W;
    localparam int FSLT_LO = FCKS_LO + CKS_W;
    localparam int FTMR_LO = FSLT_LO + SLOTNUM_W;

    typedef struct packed {
        action_t                act;
        logic [SEQNUM_W-1:0]    seq;
        logic [CKS_W-1:0]       cks;
        logic [SLOTNUM_W-1:0]   slot;
        timer_t                 tmr;
    } frame_result_t;

    frame_result_t expected_frames[$];
    frame_result_t got, want;

    // shadow of the sender window
    int                  next_seq;
    int                  first_slot;
    int                  last_slot;
    int                  in_flight;
    int                  acked_count;
    logic [SEQNUM_W-1:0] slot_seq   [WINDOW];
    logic                slot_acked [WINDOW];
    logic [CKS_W-1:0]    slot_cks   [WINDOW];

    int         err_count = 0;
    int         n_compared = 0;
    logic [7:0] act_mask = '0;
    logic [3:0] tmr_mask = '0;

    function automatic int slot_after(input int s);
        return ((int'(slot_seq[s]) + 1) % SEQ_SPACE) % WINDOW;
    endfunction

    function automatic frame_result_t advance_window(input kind_t kind, input int psum,
            input int aseq, input int anum, input int acks);
        frame_result_t r;
        int            seq;
        int            slot;
        int            cks;
        int            sf;
        int            sl;
        int            s;
        logic          inwin;
        r = '0;
        case (kind)
            KIND_MSG: begin
                if (in_flight + acked_count >= WINDOW) begin
                    r.act = ACT_FULL;
                end else begin
                    seq  = next_seq;
                    slot = seq % WINDOW;
                    cks  = seq - 1 + psum;
                    slot_seq[slot]   = seq[SEQNUM_W-1:0];
                    slot_acked[slot] = 1'b0;
                    slot_cks[slot]   = cks[CKS_W-1:0];
                    last_slot = slot;
                    in_flight++;
                    next_seq = (next_seq + 1) % SEQ_SPACE;
                    r.act  = ACT_SEND;
                    r.seq  = seq[SEQNUM_W-1:0];
                    r.cks  = cks[CKS_W-1:0];
                    r.slot = slot[SLOTNUM_W-1:0];
                    r.tmr  = (in_flight == 1) ? TMR_START : TMR_LEAVE;
                end
            end
            KIND_ACK: begin
                // checksum test is exact, no wrap
                if (aseq + anum + psum != acks) begin
                    r.act = ACT_CORRUPT;
                end else if (in_flight == 0) begin
                    r.act = ACT_DUP;
                end else begin
                    sf = slot_seq[first_slot];
                    sl = slot_seq[last_slot];
                    inwin = (sf <= sl) ? (anum >= sf && anum <= sl) : (anum >= sf || anum <= sl);
                    slot = anum % WINDOW;
                    if (!inwin || slot_acked[slot] || int'(slot_seq[slot]) != anum) begin
                        r.act = ACT_DUP;
                    end else begin
                        slot_acked[slot] = 1'b1;
                        in_flight--;
                        acked_count++;
                        r.act = ACT_NEW_ACK;
                        r.tmr = TMR_LEAVE;
                        if (slot == first_slot) begin
                            // slide over acked slots, stop at the first open frame
                            for (int i = 0; i < WINDOW; i++) begin
                                if (acked_count == 0 || !slot_acked[first_slot])
                                    break;
                                slot_acked[first_slot] = 1'b0;
                                acked_count--;
                                first_slot = slot_after(first_slot);
                            end
                            r.tmr = (in_flight > 0) ? TMR_RESTART : TMR_STOP;
                        end
                    end
                end
            end
            KIND_TIMEOUT: begin
                r.act = ACT_IDLE_TO;
                if (in_flight > 0) begin
                    s = first_slot;
                    for (int i = 0; i < WINDOW; i++) begin
                        if (!slot_acked[s]) begin
                            r.act  = ACT_RESEND;
                            r.seq  = slot_seq[s];
                            r.cks  = slot_cks[s];
                            r.slot = s[SLOTNUM_W-1:0];
                            r.tmr  = TMR_START;
                            break;
                        end
                        s = slot_after(s);
                    end
                end
            end
            default: r.act = ACT_NONE;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            next_seq    = 0;
            first_slot  = 0;
            last_slot   = WINDOW - 1;
            in_flight   = 0;
            acked_count = 0;
            for (int i = 0; i < WINDOW; i++) begin
                slot_seq[i]   = '0;
                slot_acked[i] = 1'b0;
                slot_cks[i]   = '0;
            end
            expected_frames.delete();
        end else begin
            // results first: a result never belongs to an event taken at the same edge
            if (m_tvalid && m_tready) begin
                got.act  = action_t'(m_tuser);
                got.seq  = m_tdata[FSEQ_LO +: SEQNUM_W];
                got.cks  = m_tdata[FCKS_LO +: CKS_W];
                got.slot = m_tdata[FSLT_LO +: SLOTNUM_W];
                got.tmr  = timer_t'(m_tdata[FTMR_LO +: TIMER_W]);
                act_mask[m_tuser] = 1'b1;
                tmr_mask[got.tmr] = 1'b1;
                if (expected_frames.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("[%0t] result with nothing expected: action %0d seq %0d",
                                 $time, got.act, got.seq);
                end else begin
                    want = expected_frames.pop_front();
                    n_compared++;
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"[%0t] result %0d mismatch: expected act %0d seq %0d ",
                                      "cks %0d slot %0d tmr %0d, got act %0d seq %0d ",
                                      "cks %0d slot %0d tmr %0d"},
                                     $time, n_compared, want.act, want.seq,
                                     $signed(want.cks), want.slot, want.tmr, got.act,
                                     got.seq, $signed(got.cks), got.slot, got.tmr);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_frames.push_back(advance_window(kind_t'(s_tuser),
                    int'($signed(s_tdata[PSUM_LO +: PSUM_W])),
                    int'(s_tdata[ASEQ_LO +: SEQNUM_W]),
                    int'(s_tdata[ANUM_LO +: SEQNUM_W]),
                    int'($signed(s_tdata[ACKS_LO +: CKS_W]))));
        end
        mismatches    <= err_count;
        pending       <= expected_frames.size();
        compared      <= n_compared;
        actions_seen  <= act_mask;
        timers_seen   <= tmr_mask;
        next_seq_view <= next_seq[SEQNUM_W-1:0];
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import srs_pkg::*;

    localparam int EVENT_COUNT  = 1200;    // random events after the directed part
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off to back up the block
    localparam int DRAIN_CYCLES = 60;      // quiet time after the last expected result
    localparam int CYCLE_LIMIT  = 400000;  // several times what the slowest run needs
    localparam int PAD_W        = S_TDATA_W - PSUM_W - 2*SEQNUM_W - CKS_W;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input event channel, tdata: payload_sum, ack_seqnum, ack_number, ack_checksum
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;  // kind

    // result channel, tdata: frame_seqnum, frame_checksum, frame_slot, timer_cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ACTION_W-1:0]  m_tuser;        // action

    // checker outputs
    int                  mismatches;
    int                  pending;
    int                  compared;
    logic [7:0]          actions_seen;
    logic [3:0]          timers_seen;
    logic [SEQNUM_W-1:0] next_seq_view;

    int   cycles      = 0;
    int   events_sent = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    always #2 aclk = ~aclk;

    selective_repeat_sender uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    srs_window_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .pending       (pending),
        .compared      (compared),
        .actions_seen  (actions_seen),
        .timers_seen   (timers_seen),
        .next_seq_view (next_seq_view)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // payload sum of 20 signed bytes
    function automatic int rand_psum();
        return int'($urandom_range(5100, 0)) - 2560;
    endfunction

    // offer one event and hold it until the transfer completes
    task automatic offer_event(input kind_t kind, input int psum, input int aseq,
            input int anum, input int acks);
        logic [31:0] pv;
        logic [31:0] sv;
        logic [31:0] nv;
        logic [31:0] cv;
        pv = psum;
        sv = aseq;
        nv = anum;
        cv = acks;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{PAD_W{1'b0}}, cv[CKS_W-1:0], nv[SEQNUM_W-1:0], sv[SEQNUM_W-1:0],
                     pv[PSUM_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        events_sent++;
    endtask

    // well-formed ack with a correct checksum and random content
    task automatic good_ack(input int anum);
        int aseq;
        int psum;
        aseq = $urandom_range(15, 0);
        psum = rand_psum();
        offer_event(KIND_ACK, psum, aseq, anum, aseq + anum + psum);
    endtask

    task automatic new_message(input int psum);
        offer_event(KIND_MSG, psum, $urandom_range(15, 0), $urandom_range(15, 0),
                    int'($urandom_range(8191, 0)) - 4096);
    endtask

    // mostly sends and acks near the head of the window, some timer expiries and noise
    task automatic random_event();
        int pick;
        int anum;
        int aseq;
        int psum;
        int acks;
        pick = $urandom_range(99, 0);
        psum = rand_psum();
        aseq = $urandom_range(15, 0);
        if (pick < 42) begin
            new_message(psum);
        end else if (pick < 82) begin
            // ack one of the recently sent frames, sometimes anything at all
            if ($urandom_range(9, 0) == 0)
                anum = $urandom_range(15, 0);
            else
                anum = (int'(next_seq_view) + 16 - int'($urandom_range(10, 1))) % 16;
            acks = aseq + anum + psum;
            case ($urandom_range(9, 0))
                0:       acks = acks + (($urandom_range(1, 0) == 0) ? -1 : 1)
                                * int'($urandom_range(3, 1));
                1:       acks = int'($urandom_range(8191, 0)) - 4096;
                default: ;
            endcase
            offer_event(KIND_ACK, psum, aseq, anum, acks);
        end else if (pick < 97) begin
            offer_event(KIND_TIMEOUT, psum, aseq, $urandom_range(15, 0),
                        int'($urandom_range(8191, 0)) - 4096);
        end else begin
            offer_event(KIND_RSVD, psum, aseq, $urandom_range(15, 0),
                        int'($urandom_range(8191, 0)) - 4096);
        end
    endtask

    // result sink: picks a stall style at random for every run, plus one long hold-off
    initial begin : result_sink
        int         run;
        int         style;
        logic [7:0] stall_mask;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                // block backs up and must stall its input
                m_tready  <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            style      = $urandom_range(3, 0);
            run        = $urandom_range(160, 16);
            stall_mask = 8'($urandom) | 8'h01;
            for (int phase = 0; phase < run; phase++) begin
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(1, 0));
                    2:       m_tready <= stall_mask[phase % 8];
                    default: m_tready <= ($urandom_range(9, 0) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int n;
        int burst;
        int gap;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, back to back
        offer_event(KIND_RSVD, 2540, 15, 15, 4095);       // unused kind
        offer_event(KIND_TIMEOUT, -2560, 0, 0, -4096);    // timeout, nothing outstanding
        good_ack(0);                                      // ack, nothing outstanding
        offer_event(KIND_ACK, 0, 15, 15, 4095);           // corrupted ack
        new_message(-2560);                               // first send starts the timer
        new_message(2540);
        for (int i = 0; i < 6; i++)
            new_message(rand_psum());
        new_message(rand_psum());                         // window full
        good_ack(2);                                      // new ack, not the oldest
        good_ack(2);                                      // slot already acked
        good_ack(12);                                     // outside the window
        offer_event(KIND_TIMEOUT, 0, 0, 0, 0);            // resend oldest open frame
        good_ack(0);                                      // oldest: slide one slot
        good_ack(1);                                      // oldest: slide over acked slot
        offer_event(KIND_ACK, -2560, 0, 0, -4096);        // corrupted, extreme checksum
        good_ack(7);
        good_ack(6);
        good_ack(5);
        good_ack(4);
        good_ack(3);                                      // window empties, timer stop

        // random part in bursts with gaps
        n = 0;
        while (n < EVENT_COUNT) begin
            burst = $urandom_range(24, 1);
            for (int k = 0; k < burst && n < EVENT_COUNT; k++) begin
                if (n == EVENT_COUNT / 3)
                    hold_req <= 1'b1;
                random_event();
                n++;
            end
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // drain: let the last transfer show up in the count, then wait until nothing is pending
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d events and %0d compared results, %0d mismatches",
                 events_sent, compared, mismatches);
        $display("action codes seen %b, timer commands seen %b", actions_seen, timers_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
